// File: src/msv_pkg.sv
// Shared types and constants for the motion sample stream validator.
package msv_pkg;

  localparam int JOINT_FIELDS = 6;
  localparam int JOINT_W      = 16;
  localparam int COUNT_W      = 16;
  localparam int TIME_W       = 32;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 32;
  localparam int TOL_W        = 27;

  // floor(x / 100) == (x * PCT_RECIP) >> PCT_SHIFT for any 32-bit x
  localparam logic [31:0] PCT_RECIP = 32'd1374389535;
  localparam int          PCT_SHIFT = 37;
  localparam logic [TOL_W-1:0] MIN_TOL = TOL_W'(1000);

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef enum logic [1:0] {
    CMD_BEGIN  = 2'd0,
    CMD_SAMPLE = 2'd1,
    CMD_END    = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_RANGE = 3'd1,
    ST_STEP  = 3'd2,
    ST_DUR   = 3'd3,
    ST_COUNT = 3'd4
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DECL_COUNT = 3'd0,
    REG_DECL_DUR   = 3'd1,
    REG_JOINT_MIN  = 3'd2,
    REG_JOINT_MAX  = 3'd3,
    REG_TOTAL_LIM  = 3'd4
  } cfg_reg_t;

  typedef logic [JOINT_FIELDS-1:0][JOINT_W-1:0] joint_arr_t;

  typedef struct packed {
    logic [COUNT_W-1:0] decl_count;
    logic [TIME_W-1:0]  decl_dur;
    logic [JOINT_W-1:0] joint_min;
    logic [JOINT_W-1:0] joint_max;
    logic [TIME_W-1:0]  total_lim;
    logic [TOL_W-1:0]   tol;
  } cfg_t;

  typedef struct packed {
    logic [COUNT_W-1:0] sample_count;
    logic [TIME_W-1:0]  time_sum;
    logic               seen_first;
  } seq_state_t;

endpackage

// File: src/msv_cfg.sv
// Configuration registers and the precomputed duration tolerance.
module msv_cfg
  import msv_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_t                  cfg
);

  cfg_t                 cfg_r;
  logic [63:0]          pct_prod;
  logic [TOL_W-1:0]     pct;
  logic [TOL_W-1:0]     tol_nxt;

  // duration / 100 by reciprocal, then clamp up to the minimum tolerance
  assign pct_prod = 64'(cfg_wdata) * 64'(PCT_RECIP);
  assign pct      = pct_prod[PCT_SHIFT +: TOL_W];
  assign tol_nxt  = (pct > MIN_TOL) ? pct : MIN_TOL;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.decl_count <= '0;
      cfg_r.decl_dur   <= '0;
      cfg_r.joint_min  <= JOINT_W'(500);
      cfg_r.joint_max  <= JOINT_W'(2500);
      cfg_r.total_lim  <= '1;
      cfg_r.tol        <= MIN_TOL;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_DECL_COUNT: cfg_r.decl_count <= cfg_wdata[COUNT_W-1:0];
        REG_DECL_DUR: begin
          cfg_r.decl_dur <= cfg_wdata[TIME_W-1:0];
          cfg_r.tol      <= tol_nxt;
        end
        REG_JOINT_MIN: cfg_r.joint_min <= cfg_wdata[JOINT_W-1:0];
        REG_JOINT_MAX: cfg_r.joint_max <= cfg_wdata[JOINT_W-1:0];
        REG_TOTAL_LIM: cfg_r.total_lim <= cfg_wdata[TIME_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// File: src/msv_eval.sv
// Single-pass evaluation of one command word against sequence state.
module msv_eval
  import msv_pkg::*;
#(
  parameter int JOINTS = 6
) (
  input  logic [1:0]        cmd,
  input  joint_arr_t        joints,
  input  logic [TIME_W-1:0] step,
  input  cfg_t              cfg,
  input  seq_state_t        st,
  output seq_state_t        st_nxt,
  output status_t           status
);

  localparam int NCHK = (JOINTS < JOINT_FIELDS) ? JOINTS : JOINT_FIELDS;

  logic              range_bad;
  logic              step_bad;
  logic              limit_bad;
  logic              over_bad;
  logic              end_dur_bad;
  logic [TIME_W:0]   sum_wide;
  logic [TIME_W:0]   over_diff;
  logic [TIME_W:0]   end_over;
  logic [TIME_W:0]   end_under;

  always_comb begin
    range_bad = 1'b0;
    for (int i = 0; i < NCHK; i++) begin
      if (joints[i] < cfg.joint_min || joints[i] > cfg.joint_max) begin
        range_bad = 1'b1;
      end
    end
  end

  assign step_bad  = st.seen_first ? (step == '0) : (step != '0);
  // past the limit only when the step is nonzero, even if the sum already is
  assign sum_wide  = {1'b0, st.time_sum} + {1'b0, step};
  assign limit_bad = (sum_wide > {1'b0, cfg.total_lim}) && (step != '0);
  assign over_diff = sum_wide - {1'b0, cfg.decl_dur};
  assign over_bad  = !over_diff[TIME_W] &&
                     (over_diff[TIME_W-1:0] > TIME_W'(cfg.tol));

  assign end_over    = {1'b0, st.time_sum} - {1'b0, cfg.decl_dur};
  assign end_under   = {1'b0, cfg.decl_dur} - {1'b0, st.time_sum};
  assign end_dur_bad = end_over[TIME_W] ?
                       (end_under[TIME_W-1:0] > TIME_W'(cfg.tol)) :
                       (end_over[TIME_W-1:0] > TIME_W'(cfg.tol));

  always_comb begin
    st_nxt = st;
    status = ST_OK;
    unique case (cmd)
      CMD_BEGIN: begin
        st_nxt = '0;
      end
      CMD_SAMPLE: begin
        if (range_bad) begin
          status = ST_RANGE;
        end else if (step_bad) begin
          status = ST_STEP;
        end else begin
          st_nxt.seen_first = 1'b1;
          if (limit_bad) begin
            status = ST_DUR;
          end else begin
            st_nxt.time_sum = sum_wide[TIME_W-1:0];
            if (over_bad) begin
              status = ST_DUR;
            end else if (st.sample_count != COUNT_MAX) begin
              st_nxt.sample_count = st.sample_count + COUNT_W'(1);
            end
          end
        end
      end
      CMD_END: begin
        if (st.sample_count != cfg.decl_count) begin
          status = ST_COUNT;
        end else if (end_dur_bad) begin
          status = ST_DUR;
        end
      end
      default: ;
    endcase
  end

endmodule

// File: src/motion_sample_stream_validator_unit.sv
// Path: each accepted word is held in the input register and then captured in the result
//   register; one input register then one result register, with the evaluation logic
//   between them.
// Throughput: 1 word per cycle while the result side is not stalled; the sequence state updates
//   as each word moves to the result register, so the next word sees it at once.
// Reset (rst_n low, synchronous): both stages empty, sequence state cleared,
//   configuration registers return to their defaults.
module motion_sample_stream_validator_unit
  import msv_pkg::*;
#(
  parameter int JOINTS = 6
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            in_command,
  input  logic [JOINT_W-1:0]    in_joint_0,
  input  logic [JOINT_W-1:0]    in_joint_1,
  input  logic [JOINT_W-1:0]    in_joint_2,
  input  logic [JOINT_W-1:0]    in_joint_3,
  input  logic [JOINT_W-1:0]    in_joint_4,
  input  logic [JOINT_W-1:0]    in_joint_5,
  input  logic [TIME_W-1:0]     in_step_time,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [2:0]            out_status,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t        cfg;
  logic        in_valid_r;
  logic [1:0]  cmd_r;
  joint_arr_t  joints_r;
  logic [TIME_W-1:0] step_r;
  logic        out_valid_r;
  status_t     status_r;
  status_t     status_nxt;
  seq_state_t  st_r;
  seq_state_t  st_nxt;
  logic        advance;

  msv_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  msv_eval #(.JOINTS(JOINTS)) u_eval (
    .cmd    (cmd_r),
    .joints (joints_r),
    .step   (step_r),
    .cfg    (cfg),
    .st     (st_r),
    .st_nxt (st_nxt),
    .status (status_nxt)
  );

  // move the held word to the result register when that slot frees up
  assign advance  = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd_r       <= in_command;
      joints_r[0] <= in_joint_0;
      joints_r[1] <= in_joint_1;
      joints_r[2] <= in_joint_2;
      joints_r[3] <= in_joint_3;
      joints_r[4] <= in_joint_4;
      joints_r[5] <= in_joint_5;
      step_r      <= in_step_time;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      st_r        <= '0;
    end else begin
      if (advance) begin
        out_valid_r <= 1'b1;
        st_r        <= st_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      status_r <= status_nxt;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = status_r;

endmodule

// File: src/msv_checker.sv
// Port-level checks for the validator, bound to the top level.
module msv_checker
  import msv_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] out_status
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status))
    else $error("result word changed while stalled");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status <= ST_COUNT))
    else $error("status code out of range");

  // input side stalls only behind a stalled result
  a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without output backpressure");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind motion_sample_stream_validator_unit msv_checker u_msv_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .out_status (out_status)
);

// File: verif/tb_motion_sample_stream_validator_unit.sv
// Self-checking testbench for the motion sample stream validator unit.
`timescale 1ns / 100ps

module tb_motion_sample_stream_validator_unit;
  import msv_pkg::*;

  localparam int N_JOINTS = 6;
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam logic [TIME_W-1:0] TOL_DIVISOR = 32'd100;
  localparam logic [TIME_W-1:0] TOL_FLOOR = 32'd1000;
  localparam int STALL_LIMIT = 2000;
  localparam int MAX_REPORTS = 10;

  // Mirror of the sequence checker; one status expected per accepted word.
  class status_tracker;
    logic [COUNT_W-1:0] decl_count = '0;
    logic [TIME_W-1:0]  decl_dur = '0;
    logic [JOINT_W-1:0] jmin = 16'd500;
    logic [JOINT_W-1:0] jmax = 16'd2500;
    logic [TIME_W-1:0]  tlim = '1;
    logic [COUNT_W-1:0] count = '0;
    logic [TIME_W-1:0]  tsum = '0;
    bit                 seen_first = 1'b0;
    status_t            expected_status_q[$];
    int                 fail_count = 0;

    function void write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_DECL_COUNT: decl_count = data[COUNT_W-1:0];
        REG_DECL_DUR:   decl_dur = data;
        REG_JOINT_MIN:  jmin = data[JOINT_W-1:0];
        REG_JOINT_MAX:  jmax = data[JOINT_W-1:0];
        REG_TOTAL_LIM:  tlim = data;
        default: ;
      endcase
    endfunction

    function logic [TIME_W-1:0] tolerance();
      logic [TIME_W-1:0] pct;
      pct = decl_dur / TOL_DIVISOR;
      return (pct > TOL_FLOOR) ? pct : TOL_FLOOR;
    endfunction

    function status_t validate_sample(joint_arr_t j, logic [TIME_W-1:0] step);
      logic [TIME_W-1:0] room;
      int i;
      for (i = 0; i < N_JOINTS && i < JOINT_FIELDS; i++) begin
        if (j[i] < jmin || j[i] > jmax) return ST_RANGE;
      end
      if (!seen_first) begin
        if (step != 0) return ST_STEP;
        seen_first = 1'b1;
      end else if (step == 0) begin
        return ST_STEP;
      end
      room = (tsum > tlim) ? '0 : tlim - tsum;
      if (step > room) return ST_DUR;
      tsum = tsum + step;
      // overshoot keeps the new sum but does not count the sample
      if (tsum > decl_dur && tsum - decl_dur > tolerance()) return ST_DUR;
      if (count != COUNT_MAX) count++;
      return ST_OK;
    endfunction

    function void note_word(logic [1:0] cmd, joint_arr_t j, logic [TIME_W-1:0] step);
      status_t st;
      logic [TIME_W-1:0] tol;
      st = ST_OK;
      tol = tolerance();
      case (cmd)
        CMD_BEGIN: begin
          count = '0;
          tsum = '0;
          seen_first = 1'b0;
        end
        CMD_SAMPLE: st = validate_sample(j, step);
        CMD_END: begin
          if (count != decl_count) st = ST_COUNT;
          else if (tsum > decl_dur && tsum - decl_dur > tol) st = ST_DUR;
          else if (tsum <= decl_dur && decl_dur - tsum > tol) st = ST_DUR;
        end
        default: ;
      endcase
      expected_status_q.push_back(st);
    endfunction

    function void check_status(logic [2:0] got);
      status_t want;
      if (expected_status_q.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("unexpected result word: status %0d with nothing outstanding", got);
        return;
      end
      want = expected_status_q.pop_front();
      if (got !== want) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("status mismatch: expected %0d, actual %0d", want, got);
      end
    endfunction

    function int pending();
      return expected_status_q.size();
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [1:0]            in_command = CMD_BEGIN;
  joint_arr_t            in_joints = '0;
  logic [TIME_W-1:0]     in_step_time = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [2:0]            out_status;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx = REG_DECL_COUNT;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  status_tracker tracker;
  int gap_pct = 0;
  int stall_pct = 0;
  int words_sent = 0;
  int idle_cycles = 0;

  motion_sample_stream_validator_unit #(.JOINTS(N_JOINTS)) u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_command   (in_command),
    .in_joint_0   (in_joints[0]),
    .in_joint_1   (in_joints[1]),
    .in_joint_2   (in_joints[2]),
    .in_joint_3   (in_joints[3]),
    .in_joint_4   (in_joints[4]),
    .in_joint_5   (in_joints[5]),
    .in_step_time (in_step_time),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_status   (out_status),
    .cfg_we       (cfg_we),
    .cfg_idx      (cfg_idx),
    .cfg_wdata    (cfg_wdata)
  );

  always #6 clk = ~clk;

  // Result side: random stall bursts while stall_pct is nonzero.
  initial begin
    int n;
    @(posedge clk);
    forever begin
      if (stall_pct != 0 && $urandom_range(99, 0) < stall_pct) begin
        n = $urandom_range(10, 1);
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) tracker.check_status(out_status);
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles == STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic send_word(input logic [1:0] cmd, input joint_arr_t j,
                           input logic [TIME_W-1:0] step);
    int n;
    if (gap_pct != 0 && $urandom_range(99, 0) < gap_pct) begin
      n = $urandom_range(10, 1);
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_command <= cmd;
    in_joints <= j;
    in_step_time <= step;
    do @(posedge clk); while (!in_ready);
    tracker.note_word(cmd, j, step);
    words_sent++;
  endtask

  // Drop valid and wait until every outstanding status has come back.
  task automatic drain();
    in_valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_cfg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    tracker.write_reg(idx, data);
  endtask

  task automatic set_config(input logic [COUNT_W-1:0] cnt, input logic [TIME_W-1:0] dur,
                            input logic [JOINT_W-1:0] lo, input logic [JOINT_W-1:0] hi,
                            input logic [TIME_W-1:0] lim);
    write_cfg(REG_DECL_COUNT, CFG_DATA_W'(cnt));
    write_cfg(REG_DECL_DUR, dur);
    write_cfg(REG_JOINT_MIN, CFG_DATA_W'(lo));
    write_cfg(REG_JOINT_MAX, CFG_DATA_W'(hi));
    write_cfg(REG_TOTAL_LIM, lim);
    cfg_we <= 1'b0;
  endtask

  // Joints inside [lo, hi], biased toward the limits.
  function automatic joint_arr_t good_joints(logic [JOINT_W-1:0] lo, logic [JOINT_W-1:0] hi);
    joint_arr_t j;
    int i;
    for (i = 0; i < JOINT_FIELDS; i++) begin
      case ($urandom_range(3, 0))
        0: j[i] = lo;
        1: j[i] = hi;
        default: j[i] = JOINT_W'($urandom_range(hi, lo));
      endcase
    end
    return j;
  endfunction

  task automatic run_phase(input int n_words);
    logic [COUNT_W-1:0] cnt;
    logic [TIME_W-1:0] dur, lim, per, tol, step, spread;
    logic [JOINT_W-1:0] lo, hi;
    joint_arr_t j;
    longint s;
    int r, len, k, start;
    bit mangle;
    r = $urandom_range(9, 0);
    cnt = (r == 0) ? 16'd0 : (r == 1) ? 16'hFFFF : COUNT_W'($urandom_range(8, 1));
    r = $urandom_range(9, 0);
    dur = (r == 0) ? 32'd0 : (r == 1) ? 32'hFFFF_FFFF : 32'($urandom_range(200000, 0));
    r = $urandom_range(9, 0);
    if (r == 0) begin
      lo = 16'd0;
      hi = 16'hFFFF;
    end else if (r == 1) begin
      lo = 16'd3000;
      hi = 16'd2000;
    end else begin
      lo = JOINT_W'($urandom_range(1000, 0));
      hi = JOINT_W'($urandom_range(65535, 2000));
    end
    r = $urandom_range(9, 0);
    lim = (r == 0) ? 32'd0 : (r == 1) ? dur / 2 : (r == 2) ? 32'($urandom) : 32'hFFFF_FFFF;
    set_config(cnt, dur, lo, hi, lim);

    tol = dur / TOL_DIVISOR;
    if (tol < TOL_FLOOR) tol = TOL_FLOOR;
    len = (cnt == 0 || cnt > 12) ? $urandom_range(6, 1) : int'(cnt);
    per = (len > 1) ? dur / (len - 1) : 32'd1;
    if (per == 0) per = 32'd1;
    spread = (len > 1) ? tol / (len - 1) : tol;

    start = words_sent;
    while (words_sent - start < n_words) begin
      r = $urandom_range(99, 0);
      if (r < 15) begin
        send_word(2'($urandom_range(3, 0)), joint_arr_t'({$urandom, $urandom, $urandom}),
                  32'($urandom));
      end else begin
        mangle = (r < 30);
        send_word(CMD_BEGIN, good_joints(lo, hi), 32'($urandom));
        for (k = 0; k < len; k++) begin
          j = good_joints(lo, hi);
          step = per;
          if (k == 0) begin
            step = '0;
          end else if ($urandom_range(2, 0) == 0) begin
            // wander around the tolerance edge
            s = longint'(per) + longint'($urandom_range(2 * spread + 2, 0))
                - longint'(spread) - 1;
            if (s < 1) s = 1;
            if (s > 64'hFFFF_FFFF) s = 64'hFFFF_FFFF;
            step = s[TIME_W-1:0];
          end
          if (mangle && $urandom_range(3, 0) == 0) begin
            case ($urandom_range(3, 0))
              0: j[$urandom_range(N_JOINTS - 1, 0)] = (lo != 0) ? lo - 1'b1 : hi + 1'b1;
              1: step = (k == 0) ? 32'($urandom_range(5000, 1)) : 32'd0;
              2: step = 32'($urandom);
              default: j = joint_arr_t'({$urandom, $urandom, $urandom});
            endcase
          end
          send_word(CMD_SAMPLE, j, step);
        end
        if (!(mangle && $urandom_range(3, 0) == 0))
          send_word(CMD_END, good_joints(lo, hi), 32'($urandom));
      end
    end
    drain();
  endtask

  initial begin
    joint_arr_t j;
    int ph;
    tracker = new;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    gap_pct = 20;
    stall_pct = 20;
    set_config(16'd3, 32'd10000, 16'd500, 16'd2500, 32'hFFFF_FFFF);
    j = {JOINT_FIELDS{16'd500}};
    send_word(CMD_BEGIN, j, 32'd0);
    send_word(CMD_SAMPLE, j, 32'd5);              // nonzero step on the first sample
    j = {JOINT_FIELDS{16'd2500}};
    send_word(CMD_SAMPLE, j, 32'd0);
    send_word(CMD_SAMPLE, j, 32'd0);              // zero step after the first sample
    j[3] = 16'd499;
    send_word(CMD_SAMPLE, j, 32'd100);
    j[3] = 16'd2500;
    j[5] = 16'd2501;
    send_word(CMD_SAMPLE, j, 32'd100);
    j[5] = 16'd2500;
    j[0] = 16'd0;
    j[1] = 16'hFFFF;
    send_word(CMD_SAMPLE, j, 32'd100);
    j = {JOINT_FIELDS{16'd1500}};
    send_word(CMD_SAMPLE, j, 32'd4000);
    send_word(CMD_SAMPLE, j, 32'd7001);           // overshoot one past the tolerance
    send_word(CMD_END, j, 32'd0);
    send_word(CMD_SAMPLE, j, 32'hFFFF_FFFF);      // step beyond the total ceiling
    send_word(CMD_UNUSED, ~j, 32'hFFFF_FFFF);
    send_word(CMD_BEGIN, j, 32'd0);
    send_word(CMD_SAMPLE, j, 32'd0);
    send_word(CMD_SAMPLE, j, 32'd4500);
    send_word(CMD_SAMPLE, j, 32'd4500);
    send_word(CMD_END, j, 32'd0);                 // short by exactly the tolerance
    drain();
    set_config(16'd0, 32'd0, 16'd3000, 16'd100, 32'd5000);
    send_word(CMD_SAMPLE, j, 32'd1);              // min above max rejects every joint
    drain();
    set_config(16'd0, 32'd0, 16'd0, 16'hFFFF, 32'd5000);
    j = {3{16'h0000, 16'hFFFF}};
    send_word(CMD_SAMPLE, j, 32'd1);              // sum already past the ceiling
    send_word(CMD_END, j, 32'd0);
    send_word(CMD_BEGIN, j, 32'd0);
    send_word(CMD_SAMPLE, j, 32'd0);
    send_word(CMD_SAMPLE, j, 32'd1000);
    send_word(CMD_SAMPLE, j, 32'd1);
    send_word(CMD_END, j, 32'd0);
    drain();

    for (ph = 0; ph < 10; ph++) begin
      if (ph >= 8) begin
        gap_pct = 0;
        stall_pct = 0;
      end else begin
        gap_pct = (ph % 4 == 0) ? 0 : 5 * $urandom_range(10, 1);
        stall_pct = (ph % 4 == 1) ? 0 : 5 * $urandom_range(10, 1);
      end
      run_phase(150);
    end

    if (tracker.fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// File: filelist.f
src/msv_pkg.sv
src/msv_cfg.sv
src/msv_eval.sv
src/motion_sample_stream_validator_unit.sv
src/msv_checker.sv
verif/tb_motion_sample_stream_validator_unit.sv
